@@ hdl/arop_pkg.sv @@
// Shared types and constants for the audio ring reader.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package arop_pkg;

    // parameter defaults
    localparam int DEF_RING_WORDS      = 65536;
    localparam int DEF_MAX_READ_FRAMES = 32;

    // field widths fixed by the interface
    localparam int SAMPLE_W  = 32;
    localparam int ACTION_W  = 2;
    localparam int REQ_W     = 6;
    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_FRAMES   = 8'd1;

    // register reset values and limits
    localparam logic [1:0]           RST_CHANNEL_COUNT = 2'd2;
    localparam logic [CFG_DAT_W-1:0] RST_RING_FRAMES   = 16'd24000;
    localparam int                   MAX_RING_FRAMES   = 32768;

    // controller to datapath commands
    typedef struct packed {
        logic wr_accept;   // take a write, store first word, update pointers
        logic wr_second;   // store the latched channel 1 word
        logic rd_accept;   // take a read burst, set up cursor and counts
        logic clear;       // empty the ring
        logic rd_issue;    // read memory at the cursor
        logic load_word;   // move the read word into the output register
        logic load_empty;  // load the empty-read result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic stereo;      // two channels per frame
        logic read_empty;  // a read taken now would return nothing
        logic out_free;    // output register can take a result this cycle
        logic last_word;   // cursor is on the final word of the burst
    } t_sts;

endpackage

@@ hdl/audio_ring_overwrite_planar_reader.sv @@
// Overwrite-oldest audio ring buffer with a planar burst reader.
// A write stores one frame with one port write per word; when the ring is
// full the oldest frame is dropped. A read returns min(stored, requested,
// MAX_READ_FRAMES) frames, all channel 0 words and then all channel 1 words,
// last marked; each word is first read on the registered memory read port
// and then loaded into the output register once that is free. An empty read
// returns one result with has_sample low. The output register lets the next
// item be taken while the final result still waits. Any write to a listed
// register empties the ring; the memory itself has no reset and no clearing
// pass.
// Depends on arop_pkg, arop_ctrl and arop_dpath.
`timescale 1ns / 1ps

module audio_ring_overwrite_planar_reader
    import arop_pkg::*;
#(
    parameter int RING_WORDS      = DEF_RING_WORDS,
    parameter int MAX_READ_FRAMES = DEF_MAX_READ_FRAMES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: sample_left[31:0], sample_right[63:32], silent[64],
    //        max_frames[70:65], zero pad[71]
    input  logic [71:0]          i_s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]           i_s_axis_tuser,
    // result items
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: sample_word[31:0], frame_index[36:32], frames_returned[42:37],
    //        zero pad[47:43]
    output logic [47:0]          o_m_axis_tdata,
    // tuser: has_sample[0], channel[1]
    output logic [1:0]           o_m_axis_tuser,
    output logic                 o_m_axis_tlast,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd                w_cmd;
    t_sts                w_sts;
    logic [SAMPLE_W-1:0] w_sample_word;
    logic                w_has_sample;
    logic                w_channel;
    logic [IDX_W-1:0]    w_frame_index;
    logic [REQ_W-1:0]    w_frames_returned;

    // controller
    arop_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_action  (i_s_axis_tuser[ACTION_W-1:0]),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // datapath
    arop_dpath #(
        .RING_WORDS      (RING_WORDS),
        .MAX_READ_FRAMES (MAX_READ_FRAMES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_sample_left     (i_s_axis_tdata[31:0]),
        .i_sample_right    (i_s_axis_tdata[63:32]),
        .i_silent          (i_s_axis_tdata[64]),
        .i_max_frames      (i_s_axis_tdata[70:65]),
        .i_m_ready         (i_m_axis_tready),
        .o_m_valid         (o_m_axis_tvalid),
        .o_sample_word     (w_sample_word),
        .o_has_sample      (w_has_sample),
        .o_channel         (w_channel),
        .o_frame_index     (w_frame_index),
        .o_frames_returned (w_frames_returned),
        .o_last            (o_m_axis_tlast)
    );

    // result packing
    assign o_m_axis_tdata = {5'd0, w_frames_returned, w_frame_index, w_sample_word};
    assign o_m_axis_tuser = {w_channel, w_has_sample};

endmodule

@@ hdl/arop_ctrl.sv @@
// Controller state machine of the audio ring reader.
// Decodes accepted items into datapath commands; depends on arop_pkg.
`timescale 1ns / 1ps

module arop_ctrl
    import arop_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  t_sts                i_sts,
    output t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR1,
        S_RD_ISSUE,
        S_RD_LOAD,
        S_RD_EMPTY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_s_ready;
    logic   w_accept;

    assign w_accept  = i_s_valid & r_s_ready;
    assign o_s_ready = r_s_ready;

    // next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_WRITE: begin
                            o_cmd.wr_accept = 1'b1;
                            n_state = i_sts.stereo ? S_WR1 : S_IDLE;
                        end
                        ACT_READ: begin
                            o_cmd.rd_accept = 1'b1;
                            n_state = i_sts.read_empty ? S_RD_EMPTY : S_RD_ISSUE;
                        end
                        ACT_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WR1: begin
                o_cmd.wr_second = 1'b1;
                n_state = S_IDLE;
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RD_LOAD;
            end
            S_RD_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_word = 1'b1;
                    n_state = i_sts.last_word ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_RD_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s_ready <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s_ready <= (n_state == S_IDLE);
        end
    end

endmodule

@@ hdl/arop_dpath.sv @@
// Datapath of the audio ring reader: config registers, ring memory,
// pointers, fill count, burst cursor and output register; depends on arop_pkg.
`timescale 1ns / 1ps

module arop_dpath
    import arop_pkg::*;
#(
    parameter int RING_WORDS      = DEF_RING_WORDS,
    parameter int MAX_READ_FRAMES = DEF_MAX_READ_FRAMES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [SAMPLE_W-1:0]  i_sample_left,
    input  logic [SAMPLE_W-1:0]  i_sample_right,
    input  logic                 i_silent,
    input  logic [REQ_W-1:0]     i_max_frames,
    input  logic                 i_m_ready,
    output logic                 o_m_valid,
    output logic [SAMPLE_W-1:0]  o_sample_word,
    output logic                 o_has_sample,
    output logic                 o_channel,
    output logic [IDX_W-1:0]     o_frame_index,
    output logic [REQ_W-1:0]     o_frames_returned,
    output logic                 o_last
);

    localparam int PW = (RING_WORDS > 1) ? $clog2(RING_WORDS) : 1;  // pointer
    localparam int CW = PW + 1;                                     // counts
    localparam int XW = (CW > 17) ? CW : 17;                        // capacity math
    localparam int NW = (CW > REQ_W) ? CW : REQ_W;                  // frame compare
    localparam int SW = ((CW > 7) ? CW : 7) + 1;                    // pointer sum

    // configuration
    logic                 r_cfg_ready;
    logic [1:0]           r_chan_cfg;
    logic [CFG_DAT_W-1:0] r_frames_cfg;
    logic                 w_cfg_acc;

    // ring state
    logic [SAMPLE_W-1:0]  r_mem [RING_WORDS];
    logic [PW-1:0]        r_rp;
    logic [PW-1:0]        r_wp;
    logic [CW-1:0]        r_fill;
    logic [SAMPLE_W-1:0]  r_right;
    logic [SAMPLE_W-1:0]  r_rd_data;

    // burst cursor
    logic [PW-1:0]        r_addr;
    logic [PW-1:0]        r_ch1_start;
    logic                 r_cur_ch;
    logic [IDX_W-1:0]     r_idx;
    logic [REQ_W-1:0]     r_n;

    // output register
    logic                 r_m_valid;
    logic [SAMPLE_W-1:0]  r_o_word;
    logic                 r_o_has;
    logic                 r_o_chan;
    logic [IDX_W-1:0]     r_o_idx;
    logic [REQ_W-1:0]     r_o_n;
    logic                 r_o_last;

    // derived values
    logic                 w_stereo;
    logic [XW-1:0]        w_fr_cl;
    logic [XW-1:0]        w_lim;
    logic [XW-1:0]        w_fr_lim;
    logic [XW-1:0]        w_cap_x;
    logic [CW-1:0]        w_cap;
    logic [CW-1:0]        w_ch;
    logic                 w_full;
    logic [CW-1:0]        w_have;
    logic [REQ_W-1:0]     w_want;
    logic [REQ_W-1:0]     w_nfr;
    logic [6:0]           w_total;
    logic [SW-1:0]        w_rp_sum;
    logic [PW-1:0]        w_rp_after_rd;
    logic                 w_end_run;
    logic                 w_last_word;
    logic                 w_mem_we;
    logic [SAMPLE_W-1:0]  w_mem_wdata;

    // next pointer, wrapping at the capacity
    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p,
                                            input logic [CW-1:0] cap);
        logic [CW-1:0] nx;
        nx = {1'b0, p} + CW'(1);
        return (nx >= cap) ? '0 : nx[PW-1:0];
    endfunction

    // pointer plus one frame stride, wrapping at the capacity
    function automatic logic [PW-1:0] f_step(input logic [PW-1:0] p,
                                             input logic [CW-1:0] stride,
                                             input logic [CW-1:0] cap);
        logic [CW-1:0] nx;
        logic [CW-1:0] wr;
        nx = {1'b0, p} + stride;
        wr = nx - cap;
        return (nx >= cap) ? wr[PW-1:0] : nx[PW-1:0];
    endfunction

    // effective channels and capacity in words
    always_comb begin
        w_stereo = r_chan_cfg[1];
        w_ch     = w_stereo ? CW'(2) : CW'(1);
        if (r_frames_cfg == '0) begin
            w_fr_cl = XW'(1);
        end else if (XW'(r_frames_cfg) > XW'(MAX_RING_FRAMES)) begin
            w_fr_cl = XW'(MAX_RING_FRAMES);
        end else begin
            w_fr_cl = XW'(r_frames_cfg);
        end
        w_lim    = w_stereo ? XW'(RING_WORDS / 2) : XW'(RING_WORDS);
        w_fr_lim = (w_fr_cl > w_lim) ? w_lim : w_fr_cl;
        w_cap_x  = w_stereo ? (w_fr_lim << 1) : w_fr_lim;
        w_cap    = w_cap_x[CW-1:0];
    end

    // write full check, read burst length and pointer after the burst
    always_comb begin
        w_full = ({1'b0, r_fill} + {1'b0, w_ch}) > {1'b0, w_cap};
        w_have = w_stereo ? (r_fill >> 1) : r_fill;
        w_want = (i_max_frames > REQ_W'(MAX_READ_FRAMES)) ? REQ_W'(MAX_READ_FRAMES)
                                                          : i_max_frames;
        w_nfr  = (NW'(w_have) < NW'(w_want)) ? REQ_W'(w_have) : w_want;
        w_total = w_stereo ? {w_nfr, 1'b0} : {1'b0, w_nfr};
        w_rp_sum = SW'(r_rp) + SW'(w_total);
        w_rp_after_rd = (w_rp_sum >= SW'(w_cap)) ? PW'(w_rp_sum - SW'(w_cap))
                                                 : PW'(w_rp_sum);
    end

    // burst position
    assign w_end_run   = ({1'b0, r_idx} == (r_n - REQ_W'(1)));
    assign w_last_word = w_end_run && (r_cur_ch == w_stereo);

    assign o_sts.stereo     = w_stereo;
    assign o_sts.read_empty = (w_nfr == '0);
    assign o_sts.out_free   = !r_m_valid || i_m_ready;
    assign o_sts.last_word  = w_last_word;

    assign w_cfg_acc = i_cfg_valid & r_cfg_ready;

    // ring memory, one write and one registered read port
    assign w_mem_we    = i_cmd.wr_accept | i_cmd.wr_second;
    assign w_mem_wdata = i_cmd.wr_accept ? (i_silent ? '0 : i_sample_left) : r_right;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wp] <= w_mem_wdata;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // configuration registers and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready  <= 1'b0;
            r_chan_cfg   <= RST_CHANNEL_COUNT;
            r_frames_cfg <= RST_RING_FRAMES;
            r_rp         <= '0;
            r_wp         <= '0;
            r_fill       <= '0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_CHANNEL_COUNT: begin
                        r_chan_cfg <= i_cfg_data[1:0];
                        r_rp   <= '0;
                        r_wp   <= '0;
                        r_fill <= '0;
                    end
                    CFG_RING_FRAMES: begin
                        r_frames_cfg <= i_cfg_data;
                        r_rp   <= '0;
                        r_wp   <= '0;
                        r_fill <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.clear) begin
                r_rp   <= '0;
                r_wp   <= '0;
                r_fill <= '0;
            end else if (i_cmd.wr_accept) begin
                // full ring drops its oldest frame, so the count stays
                if (w_full) begin
                    r_rp <= f_step(r_rp, w_ch, w_cap);
                end else begin
                    r_fill <= r_fill + w_ch;
                end
                r_wp <= f_adv(r_wp, w_cap);
            end else if (i_cmd.wr_second) begin
                r_wp <= f_adv(r_wp, w_cap);
            end else if (i_cmd.rd_accept) begin
                r_rp   <= w_rp_after_rd;
                r_fill <= r_fill - CW'(w_total);
            end
        end
    end

    // write latch and burst cursor
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_accept) begin
            r_right <= i_silent ? '0 : i_sample_right;
        end
        if (i_cmd.rd_accept) begin
            r_addr      <= r_rp;
            r_ch1_start <= f_adv(r_rp, w_cap);
            r_cur_ch    <= 1'b0;
            r_idx       <= '0;
            r_n         <= w_nfr;
        end else if (i_cmd.load_word) begin
            // channel 0 run done in stereo: jump to the channel 1 run
            if (w_end_run && w_stereo && !r_cur_ch) begin
                r_addr   <= r_ch1_start;
                r_cur_ch <= 1'b1;
                r_idx    <= '0;
            end else begin
                r_addr <= f_step(r_addr, w_ch, w_cap);
                r_idx  <= r_idx + IDX_W'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_word || i_cmd.load_empty) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_o_word <= r_rd_data;
            r_o_has  <= 1'b1;
            r_o_chan <= r_cur_ch;
            r_o_idx  <= r_idx;
            r_o_n    <= r_n;
            r_o_last <= w_last_word;
        end else if (i_cmd.load_empty) begin
            r_o_word <= '0;
            r_o_has  <= 1'b0;
            r_o_chan <= 1'b0;
            r_o_idx  <= '0;
            r_o_n    <= '0;
            r_o_last <= 1'b1;
        end
    end

    assign o_cfg_ready       = r_cfg_ready;
    assign o_m_valid         = r_m_valid;
    assign o_sample_word     = r_o_word;
    assign o_has_sample      = r_o_has;
    assign o_channel         = r_o_chan;
    assign o_frame_index     = r_o_idx;
    assign o_frames_returned = r_o_n;
    assign o_last            = r_o_last;

    // fill count never exceeds the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_cap)
        else $error("fill count above capacity");

    // both pointers stay inside the active ring
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wp} < w_cap) && ({1'b0, r_rp} < w_cap))
        else $error("ring pointer outside capacity");

    // stereo ring always holds whole frames
    a_whole_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stereo |-> !r_fill[0])
        else $error("odd word count in stereo ring");

    // a loaded result is not overwritten while still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_ready) |=> (r_m_valid && $stable(r_o_word)
                                       && $stable(r_o_last)))
        else $error("pending result overwritten");

endmodule

@@ sim/audio_ring_overwrite_planar_reader_tb.sv @@
// Self-checking testbench for the audio ring buffer with planar burst reads.
// Holds its own model of the ring and its read bursts; depends on arop_pkg and
// the audio_ring_overwrite_planar_reader top level.
`timescale 1ns / 1ps

module audio_ring_overwrite_planar_reader_tb;
    import arop_pkg::*;

    localparam int          CLK_PERIOD      = 10;
    localparam int          RESET_CYCLES    = 6;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          TAIL_CYCLES     = 16;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          PHASE_COUNT     = 9;
    localparam int unsigned ITEMS_PER_PHASE = 27;

    // action code that the block ignores
    localparam logic [ACTION_W-1:0]  ACT_IGNORED = 2'd3;
    // register indexes outside the register list
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 8'hFF;

    // one input item as carried on the slave side
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                silent;
        logic [REQ_W-1:0]    max_frames;
    } ring_item_t;

    // one word of a read burst
    typedef struct packed {
        logic [SAMPLE_W-1:0] word;
        logic                has_sample;
        logic                chan;
        logic [IDX_W-1:0]    frame_idx;
        logic [REQ_W-1:0]    frames_ret;
        logic                last;
    } burst_word_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

    // ring model: pointers, fill level, registers and the queue of burst words
    class ring_scoreboard;
        bit [SAMPLE_W-1:0]  ring_mem [DEF_RING_WORDS];
        int unsigned        rd_ptr;
        int unsigned        wr_ptr;
        int unsigned        fill_words;
        logic [1:0]         chan_reg;
        logic [CFG_DAT_W-1:0] frames_reg;
        burst_word_t        pending_words [$];
        int unsigned        errors;

        function new();
            chan_reg   = RST_CHANNEL_COUNT;
            frames_reg = RST_RING_FRAMES;
            errors     = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            rd_ptr     = 0;
            wr_ptr     = 0;
            fill_words = 0;
        endfunction

        function int unsigned chans();
            return (chan_reg >= 2'd2) ? 2 : 1;
        endfunction

        // capacity in words, with out-of-range frame counts folded in
        function int unsigned cap_words();
            int unsigned fr;
            fr = frames_reg;
            if (fr == 0) fr = 1;
            if (fr > MAX_RING_FRAMES) fr = MAX_RING_FRAMES;
            if (fr > DEF_RING_WORDS / chans()) fr = DEF_RING_WORDS / chans();
            return fr * chans();
        endfunction

        function int unsigned step(int unsigned p, int unsigned cap);
            return (p + 1 >= cap) ? 0 : p + 1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
            if (idx == CFG_CHANNEL_COUNT) begin
                chan_reg = value[1:0];
                empty_ring();
            end else if (idx == CFG_RING_FRAMES) begin
                frames_reg = value;
                empty_ring();
            end
        endfunction

        function void note_item(ring_item_t it);
            int unsigned       ch;
            int unsigned       cap;
            int unsigned       want;
            int unsigned       n;
            bit [SAMPLE_W-1:0] words [2];
            bit [SAMPLE_W-1:0] grab [2][32];
            burst_word_t       r;
            ch  = chans();
            cap = cap_words();
            case (it.action)
                ACT_WRITE: begin
                    words[0] = it.silent ? '0 : it.left;
                    words[1] = it.silent ? '0 : it.right;
                    // full ring: drop the oldest frame first
                    if (fill_words + ch > cap) begin
                        for (int c = 0; c < ch; c++) rd_ptr = step(rd_ptr, cap);
                        fill_words -= ch;
                    end
                    for (int c = 0; c < ch; c++) begin
                        ring_mem[wr_ptr] = words[c];
                        wr_ptr = step(wr_ptr, cap);
                    end
                    fill_words += ch;
                end
                ACT_READ: begin
                    want = (it.max_frames > DEF_MAX_READ_FRAMES) ?
                           DEF_MAX_READ_FRAMES : it.max_frames;
                    n = (fill_words / ch < want) ? fill_words / ch : want;
                    if (n == 0) begin
                        r      = '0;
                        r.last = 1'b1;
                        pending_words.push_back(r);
                    end else begin
                        // frames leave interleaved, results go out planar
                        for (int i = 0; i < n; i++) begin
                            for (int c = 0; c < ch; c++) begin
                                grab[c][i] = ring_mem[rd_ptr];
                                rd_ptr = step(rd_ptr, cap);
                            end
                        end
                        fill_words -= n * ch;
                        for (int c = 0; c < ch; c++) begin
                            for (int i = 0; i < n; i++) begin
                                r.word       = grab[c][i];
                                r.has_sample = 1'b1;
                                r.chan       = c[0];
                                r.frame_idx  = i[IDX_W-1:0];
                                r.frames_ret = n[REQ_W-1:0];
                                r.last       = (c == ch - 1) && (i == n - 1);
                                pending_words.push_back(r);
                            end
                        end
                    end
                end
                ACT_CLEAR: empty_ring();
                default: ;
            endcase
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_word(logic [47:0] tdata, logic [1:0] tuser, logic tlast);
            burst_word_t want;
            if (pending_words.size() == 0) begin
                $display("%0t: result with none expected, tdata %h tuser %b tlast %b",
                         $time, tdata, tuser, tlast);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (tdata[31:0] !== want.word)       report("sample_word", want.word, tdata[31:0]);
            if (tdata[36:32] !== want.frame_idx) report("frame_index", want.frame_idx, tdata[36:32]);
            if (tdata[42:37] !== want.frames_ret)
                report("frames_returned", want.frames_ret, tdata[42:37]);
            if (tuser[0] !== want.has_sample)    report("has_sample", want.has_sample, tuser[0]);
            if (tuser[1] !== want.chan)          report("channel", want.chan, tuser[1]);
            if (tlast !== want.last)             report("last", want.last, tlast);
        endfunction

        function int unsigned pending();
            return pending_words.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [71:0]          i_s_axis_tdata;
    logic [1:0]           i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [47:0]          o_m_axis_tdata;
    logic [1:0]           o_m_axis_tuser;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    ring_scoreboard ring_model = new();
    ring_item_t     item_q [$];

    // per-phase register settings, extremes and out-of-range values included
    logic [CFG_DAT_W-1:0] phase_ch [PHASE_COUNT] =
        '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'hFFFE, 16'd2, 16'd1, 16'd2};
    logic [CFG_DAT_W-1:0] phase_frames [PHASE_COUNT] =
        '{16'd1, 16'd3, 16'd5, 16'd0, 16'd40, 16'd37, 16'd32768, 16'd65535, 16'd16};

    audio_ring_overwrite_planar_reader u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // monitor: register writes, accepted items and results at the rising edge
    always @(posedge i_clk) begin : monitor
        ring_item_t seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) ring_model.set_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                seen.action     = i_s_axis_tuser;
                seen.left       = i_s_axis_tdata[31:0];
                seen.right      = i_s_axis_tdata[63:32];
                seen.silent     = i_s_axis_tdata[64];
                seen.max_frames = i_s_axis_tdata[70:65];
                ring_model.note_item(seen);
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                ring_model.check_word(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    // result side stalls, switching between patterns every so often
    initial begin : result_sink
        sink_mode_t  mode;
        int unsigned mode_left;
        i_m_axis_tready = 1'b0;
        mode            = SINK_OPEN;
        mode_left       = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:     i_m_axis_tready <= 1'b1;
                SINK_RANDOM:   i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                SINK_PERIODIC: i_m_axis_tready <= (mode_left % 5 == 0);
                default:       i_m_axis_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // watchdog: too many cycles without any transaction ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("audio_ring_overwrite_planar_reader_tb: done, errors");
        $finish;
    end

    function automatic ring_item_t mk_item(logic [ACTION_W-1:0] action, logic [31:0] left,
                                           logic [31:0] right, logic silent,
                                           logic [REQ_W-1:0] max_frames);
        ring_item_t it;
        it.action     = action;
        it.left       = left;
        it.right      = right;
        it.silent     = silent;
        it.max_frames = max_frames;
        return it;
    endfunction

    // random fields; request sizes lean on the legal range and full bursts
    function automatic ring_item_t random_item(logic [ACTION_W-1:0] action);
        int unsigned      pick;
        logic [REQ_W-1:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 10)      req = '0;
        else if (pick < 20) req = REQ_W'($urandom_range(33, 63));
        else if (pick < 35) req = REQ_W'(DEF_MAX_READ_FRAMES);
        else                req = REQ_W'($urandom_range(1, DEF_MAX_READ_FRAMES));
        return mk_item(action, $urandom, $urandom, ($urandom_range(0, 7) == 0), req);
    endfunction

    // runs of writes with reads between them, plus a few clears and ignored codes
    task automatic queue_items(int unsigned count);
        int unsigned made;
        int unsigned run;
        int unsigned pick;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                run = $urandom_range(1, 12);
                repeat (run) item_q.push_back(random_item(ACT_WRITE));
                made += run;
            end else if (pick < 90) begin
                item_q.push_back(random_item(ACT_READ));
                made++;
            end else if (pick < 95) begin
                item_q.push_back(random_item(ACT_CLEAR));
                made++;
            end else begin
                item_q.push_back(random_item(ACT_IGNORED));
            end
        end
    endtask

    task automatic send_item(ring_item_t it);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, it.max_frames, it.silent, it.right, it.left};
        i_s_axis_tuser  <= it.action;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic pause_sender(int unsigned cycles);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // hold the sender until every burst word is back and the block has settled
    task automatic wait_drained();
        pause_sender(0);
        while (ring_model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // send the queued items in bursts with random gaps
    task automatic send_items();
        int unsigned burst;
        int unsigned gap;
        while (item_q.size() != 0) begin
            burst = $urandom_range(1, 10);
            while (burst != 0 && item_q.size() != 0) begin
                send_item(item_q.pop_front());
                burst--;
            end
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0) wait_drained();
            else if (gap != 0) pause_sender(gap);
        end
    endtask

    initial begin : stimulus
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset settings: stereo, large ring
        item_q.push_back(mk_item(ACT_READ, '0, '0, 1'b0, 6'd1));             // empty read
        item_q.push_back(mk_item(ACT_WRITE, 32'h0, 32'hFFFFFFFF, 1'b0, '0));
        item_q.push_back(mk_item(ACT_WRITE, 32'hFFFFFFFF, 32'h0, 1'b0, 6'd63));
        item_q.push_back(mk_item(ACT_WRITE, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1, '0)); // silent
        item_q.push_back(mk_item(ACT_WRITE, 32'h55555555, 32'hAAAAAAAA, 1'b0, '0));
        item_q.push_back(mk_item(ACT_READ, '0, '0, 1'b0, 6'd0));             // zero request
        item_q.push_back(mk_item(ACT_IGNORED, $urandom, $urandom, 1'b1, 6'd7));
        item_q.push_back(mk_item(ACT_READ, '0, '0, 1'b0, 6'd63));            // oversized
        item_q.push_back(mk_item(ACT_READ, '0, '0, 1'b0, 6'd1));
        item_q.push_back(mk_item(ACT_WRITE, 32'h12345678, 32'h9ABCDEF0, 1'b0, '0));
        item_q.push_back(mk_item(ACT_WRITE, 32'hDEADBEEF, 32'h0BADF00D, 1'b0, '0));
        item_q.push_back(mk_item(ACT_WRITE, 32'h13579BDF, 32'h2468ACE0, 1'b0, '0));
        item_q.push_back(mk_item(ACT_READ, '0, '0, 1'b0, 6'd2));
        item_q.push_back(mk_item(ACT_READ, '0, '0, 1'b0, 6'd33));
        item_q.push_back(mk_item(ACT_WRITE, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0, '0));
        item_q.push_back(mk_item(ACT_CLEAR, '0, '0, 1'b0, '0));
        item_q.push_back(mk_item(ACT_READ, '0, '0, 1'b0, 6'd32));            // read after clear
        send_items();

        // random phases, each with its own ring shape
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            program_reg(CFG_CHANNEL_COUNT, phase_ch[p]);
            program_reg(CFG_RING_FRAMES, phase_frames[p]);
            if (p == 4) begin
                // writes outside the register list must leave the ring alone
                queue_items(ITEMS_PER_PHASE / 2);
                send_items();
                wait_drained();
                program_reg(CFG_UNUSED, 16'hFFFF);
                program_reg(CFG_TOP_IDX, 16'h0000);
                queue_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end else begin
                queue_items(ITEMS_PER_PHASE);
            end
            send_items();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ring_model.errors == 0)
            $display("audio_ring_overwrite_planar_reader_tb: done, clean");
        else
            $display("audio_ring_overwrite_planar_reader_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/arop_pkg.sv
hdl/arop_ctrl.sv
hdl/arop_dpath.sv
hdl/audio_ring_overwrite_planar_reader.sv
sim/audio_ring_overwrite_planar_reader_tb.sv
